[rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants and signature tables for the byte signature scanner.
// ----------------------------------------------------------------------------
package bss_pkg;

    // Longest tabled signature and default search window length in bytes.
    localparam int SIG_MAX_LEN       = 16;
    localparam int MAX_PATTERN_BYTES = 16;

    localparam int SIG_COUNT   = 30;
    localparam int GROUP_COUNT = 27;
    localparam int GROUP_W     = $clog2(GROUP_COUNT);

    localparam int DATA_W     = 8;
    localparam int OUT_TDATA_W = 32;

    typedef logic [SIG_MAX_LEN*DATA_W-1:0] sig_bytes_t;
    typedef logic [GROUP_COUNT-1:0]        group_mask_t;

    // Groups whose hit marks a kernel-only anti-cheat.
    localparam group_mask_t KERNEL_GROUPS  = group_mask_t'(27'h000007C);
    // Groups whose status is blocked pending vendor support.
    localparam group_mask_t BLOCKED_GROUPS = group_mask_t'(27'h0000003);
    // Groups that are blocked pending or possible in user mode.
    localparam group_mask_t PROOF_GROUPS   = group_mask_t'(27'h007FF83);

    // Each signature is right-justified: its newest (final) byte sits in bits
    // [7:0], the byte before it in [15:8], and so on.
    localparam sig_bytes_t SIG_BYTES [SIG_COUNT] = '{
        128'h4561737941_6E74694368656174_00,
        128'h426174746C457965,
        128'h5269636F63686574,
        128'h4541416E7469436865_6174,
        128'h416E7469436865617445_7870657274_00,
        128'h6E50726F74656374,
        128'h47616D6547756172_64,
        128'h5849474E434F4445,
        128'h56616C7665416E74_69436865_6174,
        128'h737465616D736572_76696365,
        128'h50756E6B42757374_6572,
        128'h44656E75766F,
        128'h44656E75766F,
        128'h53656375524F4D,
        128'h5361666544697363,
        128'h564D50726F746563_74,
        128'h5468656D696461,
        128'h417278616E,
        128'h537465616D737475_62,
        128'h537465616D2E646C_6C,
        128'h434547,
        128'h6D73636F7265652E_646C,
        128'h556E697479506C61_796572,
        128'h556E7265616C456E_67696E65,
        128'h554534,
        128'h554535,
        128'h6D6F6E6F2D,
        128'h584E41,
        128'h464E41,
        128'h476F646F74
    };

    localparam int SIG_LEN [SIG_COUNT] = '{
        14, 8, 8, 11, 16, 8, 9, 8, 14, 12,
        10, 6, 6, 7, 8, 9, 7, 5, 9, 9,
        3, 10, 11, 12, 3, 3, 5, 3, 3, 5
    };

    localparam logic [GROUP_W-1:0] SIG_GROUP [SIG_COUNT] = '{
        5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
        5'd10, 5'd11, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd17,
        5'd18, 5'd19, 5'd20, 5'd21, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26
    };

endpackage

[rtl/bss_matcher.sv]
// ----------------------------------------------------------------------------
// bss_matcher
// Parallel comparators of the byte window against every signature.
// ----------------------------------------------------------------------------
module bss_matcher
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = bss_pkg::MAX_PATTERN_BYTES,
    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1)
)
(
    input  logic [DATA_W-1:0] cur_byte,
    input  logic [DATA_W-1:0] window [MAX_PATTERN_BYTES-1],
    input  logic [FILL_W-1:0] fill_cnt,
    output group_mask_t       group_hit
);

    logic [DATA_W-1:0]    recent [MAX_PATTERN_BYTES];
    logic [SIG_COUNT-1:0] sig_hit;

    // Newest byte first, then the stored window.
    always_comb
    begin
        recent[0] = cur_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++)
        begin
            recent[j] = window[j-1];
        end
    end

    for (genvar i = 0; i < SIG_COUNT; i++) begin : g_sig
        if (SIG_LEN[i] <= MAX_PATTERN_BYTES) begin : g_fits
            logic [SIG_MAX_LEN-1:0] eq;
            for (genvar j = 0; j < SIG_MAX_LEN; j++) begin : g_byte
                if (j < SIG_LEN[i]) begin : g_cmp
                    assign eq[j] = (recent[j] == SIG_BYTES[i][DATA_W*j +: DATA_W]);
                end
                else begin : g_pad
                    assign eq[j] = 1'b1;
                end
            end
            // A signature cannot match before enough bytes of the buffer exist.
            assign sig_hit[i] = (fill_cnt >= FILL_W'(SIG_LEN[i])) && (&eq);
        end
        else begin : g_long
            assign sig_hit[i] = 1'b0;
        end
    end

    // Signatures that share a group are OR-ed together.
    always_comb
    begin
        group_hit = '0;
        for (int i = 0; i < SIG_COUNT; i++)
        begin
            group_hit[SIG_GROUP[i]] = group_hit[SIG_GROUP[i]] | sig_hit[i];
        end
    end

endmodule

[rtl/bss_verdict.sv]
// ----------------------------------------------------------------------------
// bss_verdict
// Derives the three compatibility verdicts from the group hit mask.
// ----------------------------------------------------------------------------
module bss_verdict
    import bss_pkg::*;
(
    input  group_mask_t hits,
    output logic        kernel_anticheat,
    output logic        runtime_proof_needed,
    output logic        compatible
);

    logic blocked;

    assign kernel_anticheat     = |(hits & KERNEL_GROUPS);
    assign blocked              = |(hits & BLOCKED_GROUPS);
    assign runtime_proof_needed = |(hits & PROOF_GROUPS);
    assign compatible           = !(kernel_anticheat || blocked);

endmodule

[rtl/byte_signature_scanner.sv]
// ----------------------------------------------------------------------------
// byte_signature_scanner
// Streams a buffer byte by byte and reports which signature groups it holds.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a buffer arrive on the s_axis word channel, one byte per word, with
// s_axis_tlast high on the final byte. Every byte is compared against all
// signatures at once, ending at that byte, and group hits are kept sticky.
// On the final byte one word leaves on m_axis carrying the group mask and the
// three verdicts; the scanner then starts afresh for the next buffer, so no
// signature ever matches across two buffers. Bytes that are not final give no
// output word.
// Throughput is one byte per cycle unless a final byte waits on a stalled
// result: the input register and the result register are separated by one
// stage of comparators, window shift and verdict logic. The result word is
// loaded into the result register as the final byte leaves the input register.
// When the receiver stalls, a waiting result blocks only the next final byte;
// ordinary bytes keep flowing. Reset (rst_n low) empties both registers and
// clears the window, the byte count and the hit mask.
// ----------------------------------------------------------------------------
module byte_signature_scanner
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = bss_pkg::MAX_PATTERN_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // last_byte

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [26:0] group_hits,
                                                   // [27] kernel_anticheat,
                                                   // [28] runtime_proof_needed,
                                                   // [29] compatible, [31:30] zero
);

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_D  = MAX_PATTERN_BYTES - 1;

    // Input register.
    logic              in_valid_reg, in_valid_next;
    logic [DATA_W-1:0] in_byte_reg,  in_byte_next;
    logic              in_last_reg,  in_last_next;

    // Scan state.
    logic [DATA_W-1:0] window_reg [WIN_D];
    logic [DATA_W-1:0] window_next [WIN_D];
    logic [FILL_W-1:0] fill_reg,  fill_next;
    group_mask_t       hit_reg,   hit_next;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg,  out_data_next;

    logic        advance;
    logic [FILL_W-1:0] fill_inc;
    group_mask_t group_hit;
    group_mask_t hit_all;
    logic        kernel_anticheat;
    logic        runtime_proof_needed;
    logic        compatible;

    // A non-final byte always moves on; a final byte needs room for its result.
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Bytes seen in this buffer including the current one, saturating.
    assign fill_inc = (fill_reg < FILL_W'(MAX_PATTERN_BYTES)) ? fill_reg + 1'b1 : fill_reg;

    bss_matcher #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_matcher (
        .cur_byte  (in_byte_reg),
        .window    (window_reg),
        .fill_cnt  (fill_inc),
        .group_hit (group_hit)
    );

    assign hit_all = hit_reg | group_hit;

    bss_verdict u_verdict (
        .hits                 (hit_all),
        .kernel_anticheat     (kernel_anticheat),
        .runtime_proof_needed (runtime_proof_needed),
        .compatible           (compatible)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_last_next   = in_last_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            in_byte_next  = s_axis_tdata;
            in_last_next  = s_axis_tlast;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            window_next[0] = in_byte_reg;
            for (int j = 1; j < WIN_D; j++)
            begin
                window_next[j] = window_reg[j-1];
            end

            if (in_last_reg)
            begin
                // The count and the mask restart; stale window bytes are
                // never read while the count is below their position.
                fill_next      = '0;
                hit_next       = '0;
                out_valid_next = 1'b1;
                out_data_next  = {(OUT_TDATA_W - GROUP_COUNT - 3)'(0), compatible,
                                  runtime_proof_needed, kernel_anticheat, hit_all};
            end
            else
            begin
                fill_next = fill_inc;
                hit_next  = hit_all;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_last_reg   <= 1'b0;
            fill_reg      <= '0;
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < WIN_D; j++)
            begin
                window_reg[j] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            in_last_reg   <= in_last_next;
            fill_reg      <= fill_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
